[hw/rtl/wfs_pkg.sv]
`timescale 1ns / 1ps

package wfs_pkg;

    localparam int LED_COUNT = 32;
    localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int COLOR_W   = 24;
    localparam int CODE_W    = 16;
    localparam int SLOT_W    = 8;
    localparam int BIT_PTR_W = 5;
    localparam logic [BIT_PTR_W-1:0] BIT_LAST = BIT_PTR_W'(COLOR_W - 1);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_ONE_CODE   = 2'd0;
    localparam logic [1:0] REG_ZERO_CODE  = 2'd1;
    localparam logic [1:0] REG_TAIL_SLOTS = 2'd2;

    localparam logic [CODE_W-1:0] ONE_CODE_RST   = 16'd60;
    localparam logic [CODE_W-1:0] ZERO_CODE_RST  = 16'd30;
    localparam logic [SLOT_W-1:0] TAIL_SLOTS_RST = 8'd50;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] one_code;
        logic [CODE_W-1:0] zero_code;
        logic [SLOT_W-1:0] tail_slots;
    } t_cfg;

    typedef struct packed {
        logic wr_en;
        logic clr;
        logic adv_bit;
        logic adv_tail;
        logic emit;
        logic last;
        logic sel_zero;
    } t_cmd;

    typedef struct packed {
        logic led_last;
        logic bit_last;
        logic slots_zero;
        logic tail_done;
    } t_status;

endpackage

[hw/rtl/wfs_if.sv]
`timescale 1ns / 1ps

interface wfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] led_addr;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, op, led_addr, red, green, blue, input ready);
    modport sink (input valid, op, led_addr, red, green, blue, output ready);
endinterface

interface wfs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pwm_code;
    logic        frame_end;

    modport source (output valid, pwm_code, frame_end, input ready);
    modport sink (input valid, pwm_code, frame_end, output ready);
endinterface

[hw/rtl/ws2812_frame_serializer_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake     Word
// i_in      in         valid/ready   op, led_addr, red, green, blue
// o_out     out        valid/ready   pwm_code, frame_end
// apb       in         psel/penable  one_code, zero_code, tail_slots
//
// A tick's code is registered and appears at the output in the cycle after the tick is accepted.
// The single output register sets the rate: a new word is taken whenever it is empty
// or being drained in the same cycle.
// Reset is synchronous and active low; it clears the color store and the pointers.
// A stalled output holds its word and blocks further input words.

module ws2812_frame_serializer_top
    import wfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    wfs_in_if.sink             i_in,
    wfs_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_fire;

    assign i_in.ready = w_in_ready;
    assign w_fire     = i_in.valid && w_in_ready;

    wfs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_op     (i_in.op),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    wfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_led_addr  (i_in.led_addr),
        .i_red       (i_in.red),
        .i_green     (i_in.green),
        .i_blue      (i_in.blue),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_out.valid),
        .o_pwm_code  (o_out.pwm_code),
        .o_frame_end (o_out.frame_end),
        .o_status    (w_status)
    );

endmodule

[hw/rtl/wfs_regs.sv]
`timescale 1ns / 1ps

module wfs_regs
    import wfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_code   <= ONE_CODE_RST;
            r_cfg.zero_code  <= ZERO_CODE_RST;
            r_cfg.tail_slots <= TAIL_SLOTS_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_ONE_CODE:   r_cfg.one_code   <= pwdata[CODE_W-1:0];
                REG_ZERO_CODE:  r_cfg.zero_code  <= pwdata[CODE_W-1:0];
                REG_TAIL_SLOTS: r_cfg.tail_slots <= pwdata[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ONE_CODE:   prdata = 32'(r_cfg.one_code);
            REG_ZERO_CODE:  prdata = 32'(r_cfg.zero_code);
            REG_TAIL_SLOTS: prdata = 32'(r_cfg.tail_slots);
            default:        prdata = 32'd0;
        endcase
    end

endmodule

[hw/rtl/wfs_ctrl.sv]
`timescale 1ns / 1ps

module wfs_ctrl
    import wfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_op,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_fire && i_op == OP_WRITE) begin
                    o_cmd.wr_en = 1'b1;
                end else if (i_fire && i_op == OP_START) begin
                    o_cmd.clr = 1'b1;
                    n_state   = ST_DATA;
                end
            end
            ST_DATA: begin
                if (i_fire && i_op == OP_TICK) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.adv_bit = 1'b1;
                    if (i_status.led_last && i_status.bit_last) begin
                        if (i_status.slots_zero) begin
                            o_cmd.last = 1'b1;
                            o_cmd.clr  = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_state = ST_TAIL;
                        end
                    end
                end
            end
            ST_TAIL: begin
                if (i_fire && i_op == OP_TICK) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel_zero = 1'b1;
                    o_cmd.adv_tail = 1'b1;
                    if (i_status.tail_done) begin
                        o_cmd.last = 1'b1;
                        o_cmd.clr  = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/wfs_dp.sv]
`timescale 1ns / 1ps

module wfs_dp
    import wfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    input  logic [7:0]        i_led_addr,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic [CODE_W-1:0] o_pwm_code,
    output logic              o_frame_end,
    output t_status           o_status
);

    logic [COLOR_W-1:0]   r_colors [LED_COUNT];
    logic [LED_AW-1:0]    r_led_ptr;
    logic [BIT_PTR_W-1:0] r_bit_ptr;
    logic [SLOT_W-1:0]    r_tail_cnt;
    logic                 r_out_valid;
    logic [CODE_W-1:0]    r_pwm_code;
    logic                 r_frame_end;
    logic                 w_in_range;
    logic [COLOR_W-1:0]   w_color;
    logic [BIT_PTR_W-1:0] w_bit_sel;
    logic [CODE_W-1:0]    w_code;

    assign w_in_range = 32'(i_led_addr) < 32'(LED_COUNT);
    assign w_color    = r_colors[r_led_ptr];
    assign w_bit_sel  = BIT_LAST - r_bit_ptr;

    always_comb begin
        if (i_cmd.sel_zero) begin
            w_code = '0;
        end else if (w_color[w_bit_sel]) begin
            w_code = i_cfg.one_code;
        end else begin
            w_code = i_cfg.zero_code;
        end
    end

    assign o_status.led_last   = r_led_ptr == LED_AW'(LED_COUNT - 1);
    assign o_status.bit_last   = r_bit_ptr == BIT_LAST;
    assign o_status.slots_zero = i_cfg.tail_slots == '0;
    assign o_status.tail_done  = ({1'b0, r_tail_cnt} + 9'd1) >= {1'b0, i_cfg.tail_slots};

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_pwm_code  = r_pwm_code;
    assign o_frame_end = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_colors[i] <= '0;
            end
        end else if (i_cmd.wr_en && w_in_range) begin
            r_colors[LED_AW'(i_led_addr)] <= {i_green, i_red, i_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_ptr  <= '0;
            r_bit_ptr  <= '0;
            r_tail_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_led_ptr  <= '0;
            r_bit_ptr  <= '0;
            r_tail_cnt <= '0;
        end else if (i_cmd.adv_bit) begin
            if (r_bit_ptr == BIT_LAST) begin
                r_bit_ptr <= '0;
                r_led_ptr <= r_led_ptr + 1'b1;
            end else begin
                r_bit_ptr <= r_bit_ptr + 1'b1;
            end
        end else if (i_cmd.adv_tail) begin
            r_tail_cnt <= r_tail_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pwm_code  <= w_code;
            r_frame_end <= i_cmd.last;
        end
    end

endmodule
